FILE: sv/lru_page_stack_defines.svh
// lru_page_stack_defines.svh: assertion macros shared by the lru page stack rtl
// no dependencies; included by the modules that carry assertions
`ifndef LRU_PAGE_STACK_DEFINES_SVH
`define LRU_PAGE_STACK_DEFINES_SVH

// same-cycle implication, disabled during reset
`define LPS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define LPS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/lps_pkg.sv
// lps_pkg: constants and command type for the lru page stack
// no dependencies; used by lps_ctrl, lps_datapath and lru_page_stack
package lps_pkg;

    localparam int unsigned IN_PAGE_W  = 16;
    localparam int unsigned WAYS_W     = 5;
    localparam int unsigned POS_OUT_W  = 4;
    localparam int unsigned COUNT_W    = 32;
    localparam int unsigned APB_DATA_W = 32;
    localparam int unsigned APB_ADDR_W = 3;

    localparam logic [WAYS_W-1:0]  WAYS_RESET = 5'd16;
    localparam logic [COUNT_W-1:0] COUNT_MAX  = 32'hFFFF_FFFF;

    // register index codes (word index from paddr)
    localparam logic REG_WAYS_IDX = 1'b0;

    typedef struct packed {
        logic load;
        logic compare;
        logic resolve;
        logic commit;
        logic cfg_write;
    } t_lps_cmd;

endpackage

FILE: sv/lru_page_stack.sv
// lru_page_stack: top level, apb register port and item handshakes
// depends on lps_pkg, lps_ctrl and lps_datapath
//
// An lru page stack of CAPACITY lanes: each request item is compared against all
// resident lanes at once, then the hit or missing page moves to the front. An item
// passes through the steps accept, lane compare, position encode, and stack update
// and result write, and the block takes no new item until the last one is written;
// a result that is not taken holds the next item in its update step. The input is
// ready in the accept step even while a result still waits. Writing ways_in_use
// (byte address 0) empties the stack; the counters keep their values.
module lru_page_stack #(
    parameter int unsigned CAPACITY  = 16,
    parameter int unsigned PAGE_BITS = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [lps_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [lps_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [lps_pkg::APB_DATA_W-1:0]     prdata,
    output logic                               pready,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic [lps_pkg::IN_PAGE_W-1:0]      i_page_number,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic                               o_fault,
    output logic [lps_pkg::POS_OUT_W-1:0]      o_hit_position,
    output logic [lps_pkg::COUNT_W-1:0]        o_request_count,
    output logic [lps_pkg::COUNT_W-1:0]        o_fault_count
);

    lps_pkg::t_lps_cmd            cmd;
    logic                         cfg_write;
    logic                         reg_sel_ways;
    logic [lps_pkg::WAYS_W-1:0]   ways;

    assign pready       = 1'b1;
    assign reg_sel_ways = (paddr[lps_pkg::APB_ADDR_W-1] == lps_pkg::REG_WAYS_IDX);
    assign cfg_write    = psel && penable && pwrite && pready && reg_sel_ways;
    assign prdata       = reg_sel_ways ? lps_pkg::APB_DATA_W'(ways) : '0;

    lps_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_cfg_write (cfg_write),
        .o_cmd       (cmd)
    );

    lps_datapath #(
        .CAPACITY  (CAPACITY),
        .PAGE_BITS (PAGE_BITS)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .i_page_number   (i_page_number),
        .i_cfg_ways      (pwdata[lps_pkg::WAYS_W-1:0]),
        .o_ways          (ways),
        .o_fault         (o_fault),
        .o_hit_position  (o_hit_position),
        .o_request_count (o_request_count),
        .o_fault_count   (o_fault_count)
    );

endmodule

FILE: sv/lps_ctrl.sv
// lps_ctrl: sequencer for one request item (load, compare, resolve, commit)
// depends on lps_pkg and lru_page_stack_defines.svh; drives lps_datapath
`include "lru_page_stack_defines.svh"

module lps_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    input  logic             i_cfg_write,
    output lps_pkg::t_lps_cmd o_cmd
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CMP  = 2'd1;
    localparam logic [1:0] ST_RES  = 2'd2;
    localparam logic [1:0] ST_UPD  = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;
    logic       r_out_valid;
    logic       n_out_valid;
    logic       slot_free;

    assign slot_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state         = r_state;
        n_out_valid     = r_out_valid && !i_out_ready;
        o_cmd           = '0;
        o_cmd.cfg_write = i_cfg_write;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_CMP;
                end
            end
            ST_CMP: begin
                o_cmd.compare = 1'b1;
                n_state       = ST_RES;
            end
            ST_RES: begin
                o_cmd.resolve = 1'b1;
                n_state       = ST_UPD;
            end
            ST_UPD: begin
                if (slot_free) begin
                    o_cmd.commit = 1'b1;
                    n_out_valid  = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;

    `LPS_ASSERT_NOW(a_rise_from_upd, i_clk, i_rst_n, $rose(r_out_valid), $past(r_state) == ST_UPD, "result raised outside update step")
    `LPS_ASSERT_NEXT(a_upd_waits, i_clk, i_rst_n, (r_state == ST_UPD) && r_out_valid && !i_out_ready, (r_state == ST_UPD) && r_out_valid, "update left while result slot busy")

endmodule

FILE: sv/lps_datapath.sv
// lps_datapath: recency stack registers, lane compare, position encode, counters
// depends on lps_pkg and lru_page_stack_defines.svh; driven by lps_ctrl commands
`include "lru_page_stack_defines.svh"

module lps_datapath #(
    parameter int unsigned CAPACITY  = 16,
    parameter int unsigned PAGE_BITS = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  lps_pkg::t_lps_cmd                  i_cmd,
    input  logic [lps_pkg::IN_PAGE_W-1:0]      i_page_number,
    input  logic [lps_pkg::WAYS_W-1:0]         i_cfg_ways,
    output logic [lps_pkg::WAYS_W-1:0]         o_ways,
    output logic                               o_fault,
    output logic [lps_pkg::POS_OUT_W-1:0]      o_hit_position,
    output logic [lps_pkg::COUNT_W-1:0]        o_request_count,
    output logic [lps_pkg::COUNT_W-1:0]        o_fault_count
);

    localparam int unsigned POS_W  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int unsigned LANE_W = $clog2(CAPACITY + 1);
    localparam int unsigned CMP_W  = (LANE_W > lps_pkg::WAYS_W) ? LANE_W : lps_pkg::WAYS_W;
    localparam int unsigned EXT_W  = lps_pkg::IN_PAGE_W + PAGE_BITS;
    localparam int unsigned PWID_W = POS_W + lps_pkg::POS_OUT_W;

    logic [lps_pkg::WAYS_W-1:0]  r_ways;
    logic [PAGE_BITS-1:0]        r_page;
    logic [PAGE_BITS-1:0]        r_pages [CAPACITY];
    logic [CAPACITY-1:0]         r_valid;
    logic [CAPACITY-1:0]         r_match;
    logic                        r_hit;
    logic [POS_W-1:0]            r_pos;
    logic                        r_fault;
    logic [lps_pkg::POS_OUT_W-1:0] r_hit_position;
    logic [lps_pkg::COUNT_W-1:0] r_req;
    logic [lps_pkg::COUNT_W-1:0] r_flt;

    logic [EXT_W-1:0]            page_ext;
    logic [CMP_W-1:0]            ways_ext;
    logic [CMP_W-1:0]            act_ways;
    logic [CAPACITY-1:0]         lane_active;
    logic [CAPACITY-1:0]         match;
    logic [CAPACITY-1:0]         shift;
    logic [POS_W-1:0]            pos_enc;
    logic [PWID_W-1:0]           pos_wide;

    assign page_ext = {PAGE_BITS'(1'b0), i_page_number};
    assign ways_ext = CMP_W'(r_ways);

    // clamp ways to 1..CAPACITY
    always_comb begin
        if (ways_ext == '0) begin
            act_ways = CMP_W'(1);
        end else if (ways_ext > CMP_W'(CAPACITY)) begin
            act_ways = CMP_W'(CAPACITY);
        end else begin
            act_ways = ways_ext;
        end
    end

    always_comb begin
        for (int k = 0; k < CAPACITY; k++) begin
            lane_active[k] = CMP_W'(k) < act_ways;
            match[k]       = r_valid[k] && lane_active[k] && (r_pages[k] == r_page);
        end
    end

    // valid pages are unique, so the match vector is one-hot or empty
    always_comb begin
        pos_enc = '0;
        for (int k = 0; k < CAPACITY; k++) begin
            if (r_match[k]) begin
                pos_enc = pos_enc | POS_W'(k);
            end
        end
    end

    always_comb begin
        shift[0] = 1'b0;
        for (int k = 1; k < CAPACITY; k++) begin
            shift[k] = r_hit ? (POS_W'(k) <= r_pos) : lane_active[k];
        end
    end

    assign pos_wide = {lps_pkg::POS_OUT_W'(1'b0), r_pos};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ways  <= lps_pkg::WAYS_RESET;
            r_valid <= '0;
            r_req   <= '0;
            r_flt   <= '0;
        end else if (i_cmd.cfg_write) begin
            r_ways  <= i_cfg_ways;
            r_valid <= '0;
        end else if (i_cmd.commit) begin
            for (int k = 1; k < CAPACITY; k++) begin
                if (shift[k]) begin
                    r_valid[k] <= r_valid[k-1];
                end
            end
            r_valid[0] <= 1'b1;
            if (r_req != lps_pkg::COUNT_MAX) begin
                r_req <= r_req + 1'b1;
            end
            if (!r_hit && (r_flt != lps_pkg::COUNT_MAX)) begin
                r_flt <= r_flt + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_page <= page_ext[PAGE_BITS-1:0];
        end
        if (i_cmd.compare) begin
            r_match <= match;
        end
        if (i_cmd.resolve) begin
            r_hit <= |r_match;
            r_pos <= pos_enc;
        end
        if (i_cmd.commit) begin
            for (int k = 1; k < CAPACITY; k++) begin
                if (shift[k]) begin
                    r_pages[k] <= r_pages[k-1];
                end
            end
            r_pages[0]     <= r_page;
            r_fault        <= !r_hit;
            r_hit_position <= r_hit ? pos_wide[lps_pkg::POS_OUT_W-1:0] : '0;
        end
    end

    assign o_ways          = r_ways;
    assign o_fault         = r_fault;
    assign o_hit_position  = r_hit_position;
    assign o_request_count = r_req;
    assign o_fault_count   = r_flt;

    `LPS_ASSERT_NOW(a_match_unique, i_clk, i_rst_n, i_cmd.resolve, $onehot0(r_match), "lane hit twice")
    `LPS_ASSERT_NEXT(a_front_loaded, i_clk, i_rst_n, i_cmd.commit, r_valid[0] && (r_pages[0] == $past(r_page)), "front lane not loaded on commit")

endmodule
